FILE: src/ldag_pkg.sv
// ----------------------------------------------------------------------------
// ldag_pkg
// Shared constants, codes and controller/datapath interface types of the
// LDA Gibbs token sampler.
// ----------------------------------------------------------------------------
package ldag_pkg;

	localparam int MAX_TOPICS    = 64;
	localparam int MAX_WORDS     = 4096;
	localparam int MAX_DOCS      = 1024;
	localparam int RANDOM_LEVELS = 10000;

	localparam int TOPIC_W = $clog2(MAX_TOPICS);
	localparam int WORD_W  = $clog2(MAX_WORDS);
	localparam int DOC_W   = $clog2(MAX_DOCS);
	localparam int RND_W   = 14;
	localparam int TU_W    = 7;
	localparam int WU_W    = 13;
	localparam int PRIOR_W = 24;
	localparam int CNT_W   = 32;
	localparam int KIND_W  = 2;

	localparam int WT_AW = TOPIC_W + WORD_W;
	localparam int DC_AW = DOC_W + TOPIC_W;

	localparam int Q       = 16;
	localparam int NUM_W   = CNT_W + Q + 1;
	localparam int BSUM_W  = WU_W + PRIOR_W;
	localparam int RATIO_W = 32;
	localparam int W_W     = 53;
	localparam int ACC_W   = W_W + TOPIC_W;
	localparam int DLO_W   = 25;
	localparam int DHI_W   = NUM_W - DLO_W;
	localparam int PLO_W   = RATIO_W + DLO_W;
	localparam int PHI_W   = RATIO_W + DHI_W;
	localparam int PROD_W  = RATIO_W + NUM_W;
	localparam int ALO_W   = 30;
	localparam int AHI_W   = ACC_W - ALO_W;
	localparam int TPA_W   = ALO_W + RND_W;
	localparam int TPB_W   = AHI_W + RND_W;
	localparam int TPROD_W = ACC_W + RND_W;

	localparam int DIV_RW = NUM_W;
	localparam int DIV_BW = RATIO_W;
	localparam int DIV_SW = 6;

	localparam logic [W_W-1:0] W_MAX = '1;

	localparam logic [KIND_W-1:0] K_ASSIGN   = 2'd0;
	localparam logic [KIND_W-1:0] K_RESAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] K_READ     = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOPICS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS  = 2'd3;

	typedef struct packed {
		logic clr_step;
		logic latch_in;
		logic rd_cur;
		logic rd_k;
		logic wr_dec;
		logic out_load;
		logic ld_numden;
		logic div_ld_ratio;
		logic mul;
		logic mul_sum;
		logic acc_step;
		logic thr_mul;
		logic thr_sum;
		logic thr_cap;
		logic cw_rd;
		logic cw_mul;
		logic cw_sum;
		logic k_clr;
		logic k_inc;
		logic set_t_k;
	} ldag_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic kind_rs;
		logic k_last;
		logic div_busy;
		logic cw_hit;
	} ldag_sts_t;

endpackage

FILE: src/lda_gibbs_token_sampler_top.sv
// After reset the block clears its count memories in a pass over all 262144
// word-topic entries, one per cycle, and stalls the request channel until done;
// configuration writes are taken throughout. Items are handled one at a time.
// An assign or read reads its counts, then loads the result registers once the
// output register is free. A resample first computes a weight for each topic in
// use, the divider producing one quotient bit per cycle for the 32-bit ratio,
// then scans the cumulative weights in the draw search until a topic qualifies,
// and rereads the counts of the drawn topic. A finished result waits in an
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
// lda_gibbs_token_sampler_top
// Collapsed Gibbs sampler for LDA tokens with on-chip count tables.
// ----------------------------------------------------------------------------
module lda_gibbs_token_sampler_top import ldag_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRIOR_W-1:0]   cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [KIND_W-1:0]    kind,
	input  logic [DOC_W-1:0]     doc,
	input  logic [WORD_W-1:0]    word,
	input  logic [TOPIC_W-1:0]   topic,
	input  logic [RND_W-1:0]     random_index,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [TOPIC_W-1:0]   new_topic,
	output logic [CNT_W-1:0]     word_topic_count,
	output logic [CNT_W-1:0]     doc_topic_count,
	output logic [CNT_W-1:0]     topic_count
);

	ldag_cmd_t cmd;
	ldag_sts_t sts;

	ldag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ldag_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (kind),
		.doc             (doc),
		.word            (word),
		.topic           (topic),
		.random_index    (random_index),
		.cmd             (cmd),
		.sts             (sts),
		.new_topic       (new_topic),
		.word_topic_count(word_topic_count),
		.doc_topic_count (doc_topic_count),
		.topic_count     (topic_count)
	);

endmodule

FILE: src/ldag_div.sv
// ----------------------------------------------------------------------------
// ldag_div
// Restoring divider, one quotient bit per cycle, with a preset partial
// remainder and a programmable number of dividend bits.
// ----------------------------------------------------------------------------
module ldag_div import ldag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_RW-1:0] rem0,
	input  logic [DIV_RW-1:0] dvsr,
	input  logic [DIV_BW-1:0] bits,
	input  logic [DIV_SW-1:0] steps,
	output logic              busy,
	output logic [DIV_BW-1:0] quot
);

	logic [DIV_RW-1:0] rem_q;
	logic [DIV_RW-1:0] dvsr_q;
	logic [DIV_BW-1:0] bits_q;
	logic [DIV_BW-1:0] quot_q;
	logic [DIV_SW-1:0] cnt_q;
	logic [DIV_RW:0]   trial;
	logic              fits;

	assign trial = {rem_q, bits_q[DIV_BW-1]};
	assign fits  = trial >= {1'b0, dvsr_q};
	assign busy  = cnt_q != '0;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem0;
			dvsr_q <= dvsr;
			bits_q <= bits;
			quot_q <= '0;
		end else if (busy) begin
			rem_q  <= fits ? DIV_RW'(trial - {1'b0, dvsr_q}) : DIV_RW'(trial);
			bits_q <= {bits_q[DIV_BW-2:0], 1'b0};
			quot_q <= {quot_q[DIV_BW-2:0], fits};
		end
	end

endmodule

FILE: src/ldag_dp.sv
// ----------------------------------------------------------------------------
// ldag_dp
// Datapath: configuration registers, count memories, weight memory,
// ratio divider, weight multiplier, accumulator and draw threshold.
// ----------------------------------------------------------------------------
module ldag_dp import ldag_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRIOR_W-1:0]   cfg_data,
	input  logic [KIND_W-1:0]    kind,
	input  logic [DOC_W-1:0]     doc,
	input  logic [WORD_W-1:0]    word,
	input  logic [TOPIC_W-1:0]   topic,
	input  logic [RND_W-1:0]     random_index,
	input  ldag_cmd_t            cmd,
	output ldag_sts_t            sts,
	output logic [TOPIC_W-1:0]   new_topic,
	output logic [CNT_W-1:0]     word_topic_count,
	output logic [CNT_W-1:0]     doc_topic_count,
	output logic [CNT_W-1:0]     topic_count
);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	// Configuration registers
	logic [PRIOR_W-1:0] alpha_q, beta_q;
	logic [TU_W-1:0]    topics_q;
	logic [WU_W-1:0]    words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= PRIOR_W'(6554);
			beta_q   <= PRIOR_W'(655);
			topics_q <= TU_W'(MAX_TOPICS);
			words_q  <= WU_W'(4096);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA:  alpha_q  <= cfg_data;
				CFG_BETA:   beta_q   <= cfg_data;
				CFG_TOPICS: topics_q <= cfg_data[TU_W-1:0];
				CFG_WORDS:  words_q  <= cfg_data[WU_W-1:0];
				default:    alpha_q  <= alpha_q;
			endcase
		end
	end

	// Effective settings and clamped input fields
	logic [TU_W-1:0]    tu_eff;
	logic [TOPIC_W-1:0] tum1;
	logic [WU_W-1:0]    wu_eff;
	logic [PRIOR_W-1:0] alpha_eff, beta_eff;

	always_comb begin
		if (topics_q == '0)
			tu_eff = TU_W'(1);
		else if (topics_q > TU_W'(MAX_TOPICS))
			tu_eff = TU_W'(MAX_TOPICS);
		else
			tu_eff = topics_q;
		tum1      = TOPIC_W'(tu_eff - 1'b1);
		wu_eff    = (words_q == '0) ? WU_W'(1) : words_q;
		alpha_eff = (alpha_q == '0) ? PRIOR_W'(1) : alpha_q;
		beta_eff  = (beta_q == '0) ? PRIOR_W'(1) : beta_q;
	end

	logic [KIND_W-1:0]  kind_q;
	logic [DOC_W-1:0]   doc_q;
	logic [WORD_W-1:0]  word_q;
	logic [TOPIC_W-1:0] t_q, tum1_q, k_q;
	logic [RND_W-1:0]   rnd_q;
	logic [PRIOR_W-1:0] alpha_e_q, beta_e_q;
	logic [BSUM_W-1:0]  bsum_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kind_q    <= kind;
			doc_q     <= (32'(doc) >= MAX_DOCS) ? DOC_W'(MAX_DOCS - 1) : doc;
			word_q    <= (32'(word) >= MAX_WORDS) ? WORD_W'(MAX_WORDS - 1) : word;
			t_q       <= ({1'b0, topic} >= tu_eff) ? tum1 : topic;
			rnd_q     <= (32'(random_index) >= RANDOM_LEVELS) ?
				RND_W'(RANDOM_LEVELS - 1) : random_index;
			tum1_q    <= tum1;
			alpha_e_q <= alpha_eff;
			beta_e_q  <= beta_eff;
			bsum_q    <= BSUM_W'(wu_eff) * BSUM_W'(beta_eff);
		end else if (cmd.set_t_k) begin
			t_q <= k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.k_clr)
			k_q <= '0;
		else if (cmd.k_inc)
			k_q <= k_q + 1'b1;
	end

	// Clearing sweep over the count memories after reset
	logic [WT_AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_step)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// Count memories
	logic [CNT_W-1:0] wt_mem [2**WT_AW];
	logic [CNT_W-1:0] dc_mem [2**DC_AW];
	logic [CNT_W-1:0] tt_mem [2**TOPIC_W];
	logic [CNT_W-1:0] wt_rd_q, dc_rd_q, tt_rd_q;

	logic [TOPIC_W-1:0] rd_t;
	logic               do_inc, mem_we;
	logic [WT_AW-1:0]   wt_wa;
	logic [DC_AW-1:0]   dc_wa;
	logic [TOPIC_W-1:0] tt_wa;
	logic [CNT_W-1:0]   wt_wd, dc_wd, tt_wd;

	always_comb begin
		rd_t   = cmd.rd_k ? k_q : t_q;
		do_inc = (kind_q == K_ASSIGN) || (kind_q == K_RESAMPLE);
		mem_we = cmd.clr_step || cmd.wr_dec || (cmd.out_load && do_inc);
		if (cmd.clr_step) begin
			wt_wa = clr_cnt_q;
			dc_wa = clr_cnt_q[DC_AW-1:0];
			tt_wa = clr_cnt_q[TOPIC_W-1:0];
			wt_wd = '0;
			dc_wd = '0;
			tt_wd = '0;
		end else begin
			wt_wa = {t_q, word_q};
			dc_wa = {doc_q, t_q};
			tt_wa = t_q;
			wt_wd = cmd.wr_dec ? sat_dec(wt_rd_q) : sat_inc(wt_rd_q);
			dc_wd = cmd.wr_dec ? sat_dec(dc_rd_q) : sat_inc(dc_rd_q);
			tt_wd = cmd.wr_dec ? sat_dec(tt_rd_q) : sat_inc(tt_rd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wt_mem[wt_wa] <= wt_wd;
			dc_mem[dc_wa] <= dc_wd;
			tt_mem[tt_wa] <= tt_wd;
		end
		if (cmd.rd_cur || cmd.rd_k) begin
			wt_rd_q <= wt_mem[{rd_t, word_q}];
			dc_rd_q <= dc_mem[{doc_q, rd_t}];
			tt_rd_q <= tt_mem[rd_t];
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			new_topic        <= t_q;
			word_topic_count <= do_inc ? sat_inc(wt_rd_q) : wt_rd_q;
			doc_topic_count  <= do_inc ? sat_inc(dc_rd_q) : dc_rd_q;
			topic_count      <= do_inc ? sat_inc(tt_rd_q) : tt_rd_q;
		end
	end

	// Per-topic weight
	logic [NUM_W-1:0]   num_q, den_q, d_q;
	logic               ratio_sat_q;
	logic [RATIO_W-1:0] ratio;
	logic [PLO_W-1:0]   p_lo_s1;
	logic [PHI_W-1:0]   p_hi_s1;
	logic [PROD_W-1:0]  prod_q;
	logic [W_W-1:0]     weight;
	logic [ACC_W-1:0]   acc_q, acc_nx;

	logic              div_start, div_busy;
	logic [DIV_RW-1:0] div_rem0, div_dvsr;
	logic [DIV_BW-1:0] div_bits, div_quot;
	logic [DIV_SW-1:0] div_steps;

	assign ratio  = ratio_sat_q ? '1 : div_quot[RATIO_W-1:0];
	assign weight = (prod_q[PROD_W-1:Q] > (PROD_W-Q)'(W_MAX)) ? W_MAX : prod_q[W_W+Q-1:Q];
	assign acc_nx = acc_q + ACC_W'(weight);

	always_ff @(posedge clk) begin
		if (cmd.ld_numden) begin
			num_q <= NUM_W'({wt_rd_q, Q'(0)}) + NUM_W'(beta_e_q);
			den_q <= NUM_W'({tt_rd_q, Q'(0)}) + NUM_W'(bsum_q);
			d_q   <= NUM_W'({dc_rd_q, Q'(0)}) + NUM_W'(alpha_e_q);
		end
		// The quotient overflows 32 bits exactly when the integer part of num
		// reaches the denominator.
		if (cmd.div_ld_ratio)
			ratio_sat_q <= NUM_W'(num_q[NUM_W-1:Q]) >= den_q;
		if (cmd.mul) begin
			p_lo_s1 <= PLO_W'(ratio) * PLO_W'(d_q[DLO_W-1:0]);
			p_hi_s1 <= PHI_W'(ratio) * PHI_W'(d_q[NUM_W-1:DLO_W]);
		end
		if (cmd.mul_sum)
			prod_q <= PROD_W'(p_lo_s1) + (PROD_W'(p_hi_s1) << DLO_W);
	end

	always_ff @(posedge clk) begin
		if (cmd.k_clr)
			acc_q <= '0;
		else if (cmd.acc_step)
			acc_q <= acc_nx;
	end

	// Cumulative weights
	logic [ACC_W-1:0] cw_mem [2**TOPIC_W];
	logic [ACC_W-1:0] cw_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_step)
			cw_mem[k_q] <= acc_nx;
		if (cmd.cw_rd)
			cw_rd_q <= cw_mem[k_q];
	end

	// Draw threshold. A cumulative weight cw reaches floor(total * r / RANDOM_LEVELS)
	// exactly when total * r - (RANDOM_LEVELS - 1) <= cw * RANDOM_LEVELS, so the
	// search compares scaled weights and no division is needed.
	logic [TPA_W-1:0]   tpa_s1, cwl_s1;
	logic [TPB_W-1:0]   tpb_s1, cwh_s1;
	logic [TPROD_W-1:0] tprod_q, thr_q, cwp_q;

	always_ff @(posedge clk) begin
		if (cmd.thr_mul) begin
			tpa_s1 <= TPA_W'(acc_q[ALO_W-1:0]) * TPA_W'(rnd_q);
			tpb_s1 <= TPB_W'(acc_q[ACC_W-1:ALO_W]) * TPB_W'(rnd_q);
		end
		if (cmd.thr_sum)
			tprod_q <= TPROD_W'(tpa_s1) + (TPROD_W'(tpb_s1) << ALO_W);
		if (cmd.thr_cap)
			thr_q <= (tprod_q > TPROD_W'(RANDOM_LEVELS - 1)) ?
				tprod_q - TPROD_W'(RANDOM_LEVELS - 1) : '0;
		if (cmd.cw_mul) begin
			cwl_s1 <= TPA_W'(cw_rd_q[ALO_W-1:0]) * TPA_W'(RANDOM_LEVELS);
			cwh_s1 <= TPB_W'(cw_rd_q[ACC_W-1:ALO_W]) * TPB_W'(RANDOM_LEVELS);
		end
		if (cmd.cw_sum)
			cwp_q <= TPROD_W'(cwl_s1) + (TPROD_W'(cwh_s1) << ALO_W);
	end

	assign div_start = cmd.div_ld_ratio;
	assign div_rem0  = DIV_RW'(num_q[NUM_W-1:Q]);
	assign div_dvsr  = den_q;
	assign div_bits  = {num_q[Q-1:0], {(DIV_BW - Q){1'b0}}};
	assign div_steps = DIV_SW'(RATIO_W);

	ldag_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.rem0  (div_rem0),
		.dvsr  (div_dvsr),
		.bits  (div_bits),
		.steps (div_steps),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	always_comb begin
		sts.clr_last = &clr_cnt_q;
		sts.kind_rs  = kind_q == K_RESAMPLE;
		sts.k_last   = k_q == tum1_q;
		sts.div_busy = div_busy;
		sts.cw_hit   = thr_q <= cwp_q;
	end

endmodule

FILE: src/ldag_ctrl.sv
// ----------------------------------------------------------------------------
// ldag_ctrl
// Sequencer of the token sampler: clearing pass, count read-modify-write,
// per-topic weight loop, threshold and topic search, result handshake.
// ----------------------------------------------------------------------------
module ldag_ctrl import ldag_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  ldag_sts_t sts,
	output ldag_cmd_t cmd
);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_RD   = 5'd2;
	localparam logic [4:0] S_RDW  = 5'd3;
	localparam logic [4:0] S_OUT  = 5'd4;
	localparam logic [4:0] S_KRD  = 5'd5;
	localparam logic [4:0] S_KWT  = 5'd6;
	localparam logic [4:0] S_KLD  = 5'd7;
	localparam logic [4:0] S_KDIV = 5'd8;
	localparam logic [4:0] S_KM1  = 5'd9;
	localparam logic [4:0] S_KM2  = 5'd10;
	localparam logic [4:0] S_KACC = 5'd11;
	localparam logic [4:0] S_THR1 = 5'd12;
	localparam logic [4:0] S_THR2 = 5'd13;
	localparam logic [4:0] S_TLD  = 5'd14;
	localparam logic [4:0] S_SRD  = 5'd15;
	localparam logic [4:0] S_SM   = 5'd16;
	localparam logic [4:0] S_SS   = 5'd17;
	localparam logic [4:0] S_SW   = 5'd18;

	logic [4:0] state_q, state_d;
	logic       final_q;
	logic       rsp_valid_q;
	logic       out_free;

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_RDW;
			end
			S_RDW: begin
				// A resample first takes the token out of its old topic.
				if (sts.kind_rs && !final_q) begin
					cmd.wr_dec = 1'b1;
					cmd.k_clr  = 1'b1;
					state_d    = S_KRD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_KRD: begin
				cmd.rd_k = 1'b1;
				state_d  = S_KWT;
			end
			S_KWT: begin
				cmd.ld_numden = 1'b1;
				state_d       = S_KLD;
			end
			S_KLD: begin
				cmd.div_ld_ratio = 1'b1;
				state_d          = S_KDIV;
			end
			S_KDIV: begin
				if (!sts.div_busy)
					state_d = S_KM1;
			end
			S_KM1: begin
				cmd.mul = 1'b1;
				state_d = S_KM2;
			end
			S_KM2: begin
				cmd.mul_sum = 1'b1;
				state_d     = S_KACC;
			end
			S_KACC: begin
				cmd.acc_step = 1'b1;
				if (sts.k_last) begin
					state_d = S_THR1;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_KRD;
				end
			end
			S_THR1: begin
				cmd.thr_mul = 1'b1;
				state_d     = S_THR2;
			end
			S_THR2: begin
				cmd.thr_sum = 1'b1;
				state_d     = S_TLD;
			end
			S_TLD: begin
				cmd.thr_cap = 1'b1;
				cmd.k_clr   = 1'b1;
				state_d     = S_SRD;
			end
			S_SRD: begin
				cmd.cw_rd = 1'b1;
				state_d   = S_SM;
			end
			S_SM: begin
				cmd.cw_mul = 1'b1;
				state_d    = S_SS;
			end
			S_SS: begin
				cmd.cw_sum = 1'b1;
				state_d    = S_SW;
			end
			S_SW: begin
				// The last topic in use is taken when no earlier one qualifies.
				if (sts.cw_hit || sts.k_last) begin
					cmd.set_t_k = 1'b1;
					state_d     = S_RD;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_SRD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			final_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.latch_in)
				final_q <= 1'b0;
			else if (cmd.set_t_k)
				final_q <= 1'b1;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

FILE: src/ldag_chk.sv
// ----------------------------------------------------------------------------
// ldag_chk
// Port-level checks of the token sampler, bound to the top level.
// ----------------------------------------------------------------------------
module ldag_chk import ldag_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input logic [TOPIC_W-1:0]   new_topic,
	input logic [CNT_W-1:0]     word_topic_count,
	input logic [CNT_W-1:0]     doc_topic_count,
	input logic [CNT_W-1:0]     topic_count
);

	// A stalled result stays valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(new_topic) && $stable(word_topic_count)
			&& $stable(doc_topic_count) && $stable(topic_count))
		else $error("result payload changed while stalled");

	// Only one transaction is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in work");

	// A new result frees the request side in the same cycle.
	a_rsp_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !req_stall)
		else $error("request side still stalled after result");

endmodule

bind lda_gibbs_token_sampler_top ldag_chk u_ldag_chk (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LDA Gibbs token sampler. A scoreboard model keeps
// its own copy of the count tables and priors, predicts each result as a
// request transaction is accepted, and compares responses in order. Stimulus
// runs in phases with different prior and size settings, with random idling on
// both channels in all but the last phase.
// ----------------------------------------------------------------------------
module testbench import ldag_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000000;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [DOC_W-1:0]   doc;
		logic [WORD_W-1:0]  word;
		logic [TOPIC_W-1:0] topic;
		logic [RND_W-1:0]   rnd;
	} token_req_t;

	typedef struct packed {
		logic [TOPIC_W-1:0] topic;
		logic [CNT_W-1:0]   wt;
		logic [CNT_W-1:0]   dt;
		logic [CNT_W-1:0]   tt;
	} count_rsp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PRIOR_W-1:0]   cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [KIND_W-1:0]    kind = '0;
	logic [DOC_W-1:0]     doc = '0;
	logic [WORD_W-1:0]    word = '0;
	logic [TOPIC_W-1:0]   topic = '0;
	logic [RND_W-1:0]     random_index = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [TOPIC_W-1:0]   new_topic;
	logic [CNT_W-1:0]     word_topic_count;
	logic [CNT_W-1:0]     doc_topic_count;
	logic [CNT_W-1:0]     topic_count;

	lda_gibbs_token_sampler_top uut (.*);

	always #4 clk = ~clk;

	// Shadow registers, raw as written.
	logic [PRIOR_W-1:0] sh_alpha = 24'd6554;
	logic [PRIOR_W-1:0] sh_beta = 24'd655;
	logic [TU_W-1:0]    sh_topics = 7'd64;
	logic [WU_W-1:0]    sh_words = 13'd4096;

	logic [CNT_W-1:0] wt_cnt [int];
	logic [CNT_W-1:0] dt_cnt [int];
	logic [CNT_W-1:0] tt_cnt [int];

	token_req_t pending_reqs[$];
	count_rsp_t expected_counts[$];
	int         error_count = 0;
	bit         idling_on = 1'b1;
	int         send_gap = 0;
	int         stall_left = 0;
	int         quiet_cycles = 0;

	function automatic logic [CNT_W-1:0] cnt_get(input int sel, input int idx);
		if (sel == 0) return wt_cnt.exists(idx) ? wt_cnt[idx] : '0;
		if (sel == 1) return dt_cnt.exists(idx) ? dt_cnt[idx] : '0;
		return tt_cnt.exists(idx) ? tt_cnt[idx] : '0;
	endfunction

	function automatic void counts_bump(input int d, input int w, input int t, input bit up);
		logic [CNT_W-1:0] v [3];
		int idx [3];
		idx[0] = t * MAX_WORDS + w;
		idx[1] = d * MAX_TOPICS + t;
		idx[2] = t;
		for (int i = 0; i < 3; i++) begin
			v[i] = cnt_get(i, idx[i]);
			if (up && v[i] != '1) v[i] = v[i] + 1;
			if (!up && v[i] != '0) v[i] = v[i] - 1;
		end
		wt_cnt[idx[0]] = v[0];
		dt_cnt[idx[1]] = v[1];
		tt_cnt[idx[2]] = v[2];
	endfunction

	// Applies one token transaction to the shadow tables and returns its counts.
	function automatic count_rsp_t gibbs_token_step(input token_req_t r);
		int           tu, t, d, w, rn;
		logic [63:0]  wu, alpha, beta, bsum, acc;
		logic [63:0]  cum [MAX_TOPICS];
		logic [127:0] num, den, ratio, prod, thr;
		count_rsp_t   res;
		tu = (sh_topics == 0) ? 1 : (sh_topics > MAX_TOPICS) ? MAX_TOPICS : int'(sh_topics);
		wu = (sh_words == 0) ? 64'd1 : 64'(sh_words);
		alpha = (sh_alpha == 0) ? 64'd1 : 64'(sh_alpha);
		beta = (sh_beta == 0) ? 64'd1 : 64'(sh_beta);
		d = int'(r.doc);
		w = int'(r.word);
		t = (int'(r.topic) >= tu) ? tu - 1 : int'(r.topic);
		rn = (int'(r.rnd) >= RANDOM_LEVELS) ? RANDOM_LEVELS - 1 : int'(r.rnd);
		if (r.kind == K_ASSIGN) begin
			counts_bump(d, w, t, 1'b1);
		end else if (r.kind == K_RESAMPLE) begin
			counts_bump(d, w, t, 1'b0);
			bsum = wu * beta;
			acc = '0;
			for (int k = 0; k < tu; k++) begin
				num = (128'(cnt_get(0, k * MAX_WORDS + w)) << 16) + beta;
				den = (128'(cnt_get(2, k)) << 16) + bsum;
				if (num / den >= 65536) ratio = 128'hFFFF_FFFF;
				else ratio = (num << 16) / den;
				prod = (ratio * ((128'(cnt_get(1, d * MAX_TOPICS + k)) << 16) + alpha)) >> 16;
				if (prod > 128'(W_MAX)) prod = 128'(W_MAX);
				acc = acc + prod[63:0];
				cum[k] = acc;
			end
			thr = (128'(acc) * rn) / RANDOM_LEVELS;
			t = tu - 1;
			for (int k = 0; k < tu; k++) begin
				if (128'(cum[k]) >= thr) begin
					t = k;
					break;
				end
			end
			counts_bump(d, w, t, 1'b1);
		end
		res.topic = TOPIC_W'(t);
		res.wt = cnt_get(0, t * MAX_WORDS + w);
		res.dt = cnt_get(1, d * MAX_TOPICS + t);
		res.tt = cnt_get(2, t);
		return res;
	endfunction

	// Request driver: predicts on acceptance, then presents the next item.
	always @(posedge clk or negedge arst_n) begin
		token_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				expected_counts.insert(expected_counts.size(),
					gibbs_token_step({kind, doc, word, topic, random_index}));
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					kind <= nxt.kind;
					doc <= nxt.doc;
					word <= nxt.word;
					topic <= nxt.topic;
					random_index <= nxt.rnd;
					req_valid <= 1'b1;
					if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor with random backpressure.
	always @(posedge clk or negedge arst_n) begin
		count_rsp_t exp_c;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_counts.size() == 0) begin
					$error("response transaction with nothing expected");
					error_count++;
				end else begin
					exp_c = expected_counts.pop_front();
					if (new_topic !== exp_c.topic) begin
						$error("new_topic expected %0d actual %0d", exp_c.topic, new_topic);
						error_count++;
					end
					if (word_topic_count !== exp_c.wt) begin
						$error("word_topic_count expected %0d actual %0d", exp_c.wt,
							word_topic_count);
						error_count++;
					end
					if (doc_topic_count !== exp_c.dt) begin
						$error("doc_topic_count expected %0d actual %0d", exp_c.dt,
							doc_topic_count);
						error_count++;
					end
					if (topic_count !== exp_c.tt) begin
						$error("topic_count expected %0d actual %0d", exp_c.tt, topic_count);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (idling_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRIOR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ALPHA: sh_alpha = val;
			CFG_BETA: sh_beta = val;
			CFG_TOPICS: sh_topics = val[TU_W-1:0];
			default: sh_words = val[WU_W-1:0];
		endcase
	endtask

	task automatic settings(input int a, input int b, input int tu, input int wu);
		write_reg(CFG_ALPHA, PRIOR_W'(a));
		write_reg(CFG_BETA, PRIOR_W'(b));
		write_reg(CFG_TOPICS, PRIOR_W'(tu));
		write_reg(CFG_WORDS, PRIOR_W'(wu));
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_reqs.size() > 0 || req_valid || send_gap > 0 ||
			expected_counts.size() > 0)
			@(posedge clk);
	endtask

	task automatic push_req(input int k, input int d, input int w, input int t, input int r);
		token_req_t q;
		q.kind = KIND_W'(k);
		q.doc = DOC_W'(d);
		q.word = WORD_W'(w);
		q.topic = TOPIC_W'(t);
		q.rnd = RND_W'(r);
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	// Mostly assign/resample traffic on a few hot documents and words so the
	// counts build up, with some reads and fully random noise.
	task automatic random_phase(input int n);
		int hot_docs [4];
		int hot_words [6];
		token_req_t pool [$];
		token_req_t q;
		int sel;
		for (int i = 0; i < 4; i++) hot_docs[i] = $urandom_range(0, MAX_DOCS - 1);
		for (int i = 0; i < 6; i++) hot_words[i] = $urandom_range(0, MAX_WORDS - 1);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			q.doc = DOC_W'(hot_docs[$urandom_range(0, 3)]);
			q.word = WORD_W'(hot_words[$urandom_range(0, 5)]);
			q.topic = TOPIC_W'($urandom_range(0, 15));
			q.rnd = RND_W'($urandom_range(0, RANDOM_LEVELS - 1));
			if (sel < 35 || pool.size() == 0) begin
				q.kind = K_ASSIGN;
				pool.insert(pool.size(), q);
			end else if (sel < 75) begin
				q = pool[$urandom_range(0, pool.size() - 1)];
				q.kind = K_RESAMPLE;
				q.rnd = RND_W'($urandom_range(0, RANDOM_LEVELS - 1));
			end else if (sel < 90) begin
				q.kind = K_READ;
			end else begin
				q = token_req_t'({$urandom, $urandom});
			end
			pending_reqs.insert(pending_reqs.size(), q);
		end
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: edges of every field, all kinds, draw clamping.
		push_req(K_ASSIGN, 0, 0, 0, 0);
		push_req(K_ASSIGN, 1023, 4095, 63, 16383);
		push_req(K_ASSIGN, 1023, 4095, 63, 0);
		push_req(K_READ, 0, 0, 0, 0);
		push_req(3, 1023, 4095, 63, 16383);
		push_req(K_RESAMPLE, 1023, 4095, 63, 0);
		push_req(K_RESAMPLE, 0, 0, 0, 9999);
		push_req(K_RESAMPLE, 5, 7, 0, 0);
		push_req(K_RESAMPLE, 1023, 4095, 63, 16383);
		push_req(K_READ, 1023, 4095, 10, 5000);
		wait_drained();

		// Out-of-range topic and zero priors and sizes.
		settings(0, 0, 3, 0);
		push_req(K_ASSIGN, 1, 2, 63, 0);
		push_req(K_ASSIGN, 1, 2, 2, 0);
		push_req(K_RESAMPLE, 1, 2, 40, 9999);
		push_req(K_RESAMPLE, 1, 2, 0, 0);
		push_req(K_READ, 1, 2, 63, 0);
		wait_drained();
		settings(5, 9, 0, 1);
		push_req(K_ASSIGN, 1, 2, 5, 0);
		push_req(K_RESAMPLE, 1, 2, 5, 7000);
		push_req(K_READ, 3, 2, 63, 0);
		wait_drained();

		settings(6554, 655, 8, 4096);
		random_phase(160);
		settings(16777215, 16777215, 127, 8191);
		random_phase(25);
		settings(1, 1, 2, 1);
		random_phase(160);
		settings(0, 16777215, 5, 4096);
		random_phase(150);
		settings(16777215, 1, 4, 2);
		random_phase(150);
		settings($urandom_range(1, 16777215), $urandom_range(1, 16777215), $urandom_range(1, 16),
			$urandom_range(1, 4096));
		random_phase(150);
		settings($urandom_range(1, 200000), $urandom_range(1, 20000), $urandom_range(2, 10),
			$urandom_range(1, 8191));
		random_phase(150);
		idling_on = 1'b0;
		settings(6554, 655, 6, 4096);
		random_phase(200);

		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule
